[hw/rtl/comment_and_string_filter_unit_assert.svh]
// assertion macros shared by the filter modules
`ifndef COMMENT_AND_STRING_FILTER_UNIT_ASSERT_SVH
`define COMMENT_AND_STRING_FILTER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// checked only outside reset
`define CSF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
// checked on every edge, reset included
`define CSF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);
`else
`define CSF_ASSERT(lbl, prop, msg)
`define CSF_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[hw/rtl/csf_pkg.sv]
`timescale 1ns / 1ps
package csf_pkg;

    // character width and comment nesting limit
    localparam int CHAR_BITS = 16;
    localparam int MAX_LEVEL = 16;
    localparam int OUT_BITS  = 16;

    // result queue depth
    localparam int QUEUE_DEPTH = 4;

    // characters of interest
    localparam logic [OUT_BITS-1:0] CH_DASH  = 16'h002D;
    localparam logic [OUT_BITS-1:0] CH_OPEN  = 16'h005B;
    localparam logic [OUT_BITS-1:0] CH_CLOSE = 16'h005D;
    localparam logic [OUT_BITS-1:0] CH_EQ    = 16'h003D;
    localparam logic [OUT_BITS-1:0] CH_NL    = 16'h000A;
    localparam logic [OUT_BITS-1:0] CH_BSL   = 16'h005C;
    localparam logic [OUT_BITS-1:0] CH_DQ    = 16'h0022;
    localparam logic [OUT_BITS-1:0] CH_SQ    = 16'h0027;
    localparam logic [OUT_BITS-1:0] CH_BQ    = 16'h0060;

    localparam logic [4:0] EQ_SAT = 5'd31;

    typedef enum logic [2:0] {
        MODE_CODE    = 3'd0,
        MODE_DASHES  = 3'd1,
        MODE_OPEN_EQ = 3'd2,
        MODE_LINE    = 3'd3,
        MODE_BLOCK   = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        DELIM_NONE = 2'd0,
        DELIM_DQ   = 2'd1,
        DELIM_SQ   = 2'd2,
        DELIM_BQ   = 2'd3
    } delim_t;

    typedef struct packed {
        logic       held_dash;
        mode_t      mode;
        logic [4:0] block_level;
        logic [4:0] equals_run;
        logic       close_seen;
        delim_t     delim;
        logic       escape;
    } state_t;

    typedef struct packed {
        logic [OUT_BITS-1:0] ch;
        logic                keep;
        logic                last;
    } result_t;

    // results of one transaction: count, then first and second result
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } step_out_t;

endpackage

[hw/rtl/csf_step.sv]
`timescale 1ns / 1ps
module csf_step (
    input  logic [15:0]         char_code,
    input  logic                end_of_text,
    input  csf_pkg::state_t     state_cur,
    output csf_pkg::state_t     state_nxt,
    output csf_pkg::step_out_t  res
);

    logic [csf_pkg::OUT_BITS-1:0] c;
    logic [5:0]                   close_level;

    // keep only the low character bits
    always_comb begin
        for (int i = 0; i < csf_pkg::OUT_BITS; i++) begin
            c[i] = (i < csf_pkg::CHAR_BITS) ? char_code[i] : 1'b0;
        end
    end

    assign close_level = {1'b0, state_cur.equals_run} + 6'd1;

    // one character of state update
    always_comb begin
        csf_pkg::state_t s;
        s = state_cur;
        res = '0;
        if (end_of_text) begin
            if (state_cur.held_dash) begin
                res.count = 2'd1;
                res.first = '{ch: csf_pkg::CH_DASH, keep: 1'b1, last: 1'b1};
            end
            s = '0;
        end else if (state_cur.held_dash && c == csf_pkg::CH_DASH) begin
            // dash pair opens a comment
            s.held_dash = 1'b0;
            s.mode = csf_pkg::MODE_DASHES;
            res.count = 2'd2;
            res.first = '{ch: csf_pkg::CH_DASH, keep: 1'b0, last: 1'b0};
            res.second = '{ch: c, keep: 1'b0, last: 1'b1};
        end else if (!state_cur.held_dash && state_cur.mode != csf_pkg::MODE_CODE &&
                     state_cur.mode <= csf_pkg::MODE_BLOCK) begin
            // comment text, always skipped
            res.count = 2'd1;
            res.first = '{ch: c, keep: 1'b0, last: 1'b1};
            case (state_cur.mode)
                csf_pkg::MODE_DASHES: begin
                    if (c == csf_pkg::CH_NL) begin
                        s.mode = csf_pkg::MODE_CODE;
                    end else if (c == csf_pkg::CH_OPEN) begin
                        s.mode = csf_pkg::MODE_OPEN_EQ;
                        s.equals_run = '0;
                    end else begin
                        s.mode = csf_pkg::MODE_LINE;
                    end
                end
                csf_pkg::MODE_OPEN_EQ: begin
                    if (c == csf_pkg::CH_OPEN) begin
                        s.mode = csf_pkg::MODE_BLOCK;
                        s.block_level = close_level[4:0];
                        s.equals_run = '0;
                        s.close_seen = 1'b0;
                    end else if (c == csf_pkg::CH_EQ) begin
                        if (state_cur.equals_run >= 5'(csf_pkg::MAX_LEVEL - 1)) begin
                            s.mode = csf_pkg::MODE_LINE;
                            s.equals_run = '0;
                        end else begin
                            s.equals_run = close_level[4:0];
                        end
                    end else if (c == csf_pkg::CH_NL) begin
                        s.mode = csf_pkg::MODE_CODE;
                        s.equals_run = '0;
                    end else begin
                        s.mode = csf_pkg::MODE_LINE;
                        s.equals_run = '0;
                    end
                end
                csf_pkg::MODE_LINE: begin
                    if (c == csf_pkg::CH_NL) begin
                        s.mode = csf_pkg::MODE_CODE;
                    end
                end
                default: begin
                    // block comment: watch for the closing bracket run
                    if (c == csf_pkg::CH_CLOSE) begin
                        if (state_cur.close_seen &&
                            close_level == {1'b0, state_cur.block_level}) begin
                            s.mode = csf_pkg::MODE_CODE;
                            s.block_level = '0;
                            s.close_seen = 1'b0;
                        end else begin
                            s.close_seen = 1'b1;
                        end
                        s.equals_run = '0;
                    end else if (c == csf_pkg::CH_EQ) begin
                        if (state_cur.close_seen && state_cur.equals_run < csf_pkg::EQ_SAT) begin
                            s.equals_run = close_level[4:0];
                        end
                    end else begin
                        s.close_seen = 1'b0;
                        s.equals_run = '0;
                    end
                end
            endcase
        end else begin
            // code character, possibly releasing a held dash first
            s.mode = csf_pkg::MODE_CODE;
            if (state_cur.held_dash) begin
                s.held_dash = 1'b0;
                res.count = 2'd2;
                res.first = '{ch: csf_pkg::CH_DASH, keep: 1'b1, last: 1'b0};
                res.second = '{ch: c, keep: 1'b1, last: 1'b1};
            end else if (state_cur.delim == csf_pkg::DELIM_NONE && c == csf_pkg::CH_DASH) begin
                s.held_dash = 1'b1;
                res.count = 2'd0;
            end else begin
                res.count = 2'd1;
                res.first = '{ch: c, keep: 1'b1, last: 1'b1};
            end
            if (!s.held_dash) begin
                if (state_cur.delim == csf_pkg::DELIM_NONE) begin
                    s.escape = 1'b0;
                    if (c == csf_pkg::CH_DQ) begin
                        s.delim = csf_pkg::DELIM_DQ;
                    end else if (c == csf_pkg::CH_SQ) begin
                        s.delim = csf_pkg::DELIM_SQ;
                    end else if (c == csf_pkg::CH_BQ) begin
                        s.delim = csf_pkg::DELIM_BQ;
                    end else begin
                        s.delim = csf_pkg::DELIM_NONE;
                    end
                end else begin
                    s.escape = (c == csf_pkg::CH_BSL) && !state_cur.escape;
                    case (state_cur.delim)
                        csf_pkg::DELIM_DQ: begin
                            if (c == csf_pkg::CH_DQ && !s.escape) s.delim = csf_pkg::DELIM_NONE;
                        end
                        csf_pkg::DELIM_SQ: begin
                            if (c == csf_pkg::CH_SQ && !s.escape) s.delim = csf_pkg::DELIM_NONE;
                        end
                        default: begin
                            if (c == csf_pkg::CH_BQ && !s.escape) s.delim = csf_pkg::DELIM_NONE;
                        end
                    endcase
                end
            end
        end
        state_nxt = s;
    end

endmodule

[hw/rtl/csf_out_queue.sv]
`timescale 1ns / 1ps
`include "comment_and_string_filter_unit_assert.svh"
module csf_out_queue #(
    parameter int DEPTH = csf_pkg::QUEUE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  csf_pkg::step_out_t  res,
    output logic                room_two,
    output csf_pkg::result_t    head,
    output logic                head_valid,
    input  logic                pop_ready
);

    localparam int PW = $clog2(DEPTH);

    csf_pkg::result_t q_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PW:0]      count_reg, count_next;
    logic [1:0]       push_n;
    logic             pop;
    logic [PW-1:0]    wr_ptr_b;

    assign push_n     = push ? res.count : 2'd0;
    assign head_valid = (count_reg != '0);
    assign pop        = head_valid && pop_ready;
    assign head       = q_reg[rd_ptr_reg];
    assign room_two   = (count_reg <= (PW+1)'(DEPTH - 2));
    assign wr_ptr_b   = wr_ptr_reg + PW'(1);

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg + PW'(push_n);
        rd_ptr_next = rd_ptr_reg + (pop ? PW'(1) : PW'(0));
        count_next  = count_reg + (PW+1)'(push_n) - (pop ? (PW+1)'(1) : (PW+1)'(0));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // result storage
    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            q_reg[wr_ptr_reg] <= res.first;
        end
        if (push_n == 2'd2) begin
            q_reg[wr_ptr_b] <= res.second;
        end
    end

    `CSF_ASSERT(a_count_bound, count_reg <= (PW+1)'(DEPTH), "result queue overfilled")
    `CSF_ASSERT(a_push_room, (push_n != 2'd0) |-> room_two, "push without room in queue")
    `CSF_ASSERT(a_count_hold, (push_n == 2'd0 && !pop) |=> $stable(count_reg), "count moved while idle")

endmodule

[hw/rtl/comment_and_string_filter_unit.sv]
`timescale 1ns / 1ps
`include "comment_and_string_filter_unit_assert.svh"
// results enter a registered queue and are offered on the m_ side in order
// throughput: one character per cycle while the queue has room for two results
// a released held dash adds a result; the four-entry queue absorbs it and output stalls
// reset: synchronous, active low on aresetn; clears filter state and empties the queue
// an end-of-text transaction also returns the filter state to its reset value
module comment_and_string_filter_unit #(
    parameter int QUEUE_DEPTH = csf_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] char_code
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] out_char
    output logic        m_tuser,   // [0] keep
    output logic        m_tlast    // last
);

    csf_pkg::state_t    state_reg, state_next, state_step;
    csf_pkg::step_out_t res;
    csf_pkg::result_t   head;
    logic               accept;
    logic               room_two;

    assign accept = s_tvalid && s_tready;
    assign s_tready = room_two;

    csf_step u_step (
        .char_code   (s_tdata),
        .end_of_text (s_tlast),
        .state_cur   (state_reg),
        .state_nxt   (state_step),
        .res         (res)
    );

    // filter state advances on each accepted transaction
    assign state_next = accept ? state_step : state_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else begin
            state_reg <= state_next;
        end
    end

    csf_out_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (accept),
        .res        (res),
        .room_two   (room_two),
        .head       (head),
        .head_valid (m_tvalid),
        .pop_ready  (m_tready)
    );

    assign m_tdata = head.ch;
    assign m_tuser = head.keep;
    assign m_tlast = head.last;

    `CSF_ASSERT(a_held_code, state_reg.held_dash |-> (state_reg.mode == csf_pkg::MODE_CODE), "dash held inside comment")
    `CSF_ASSERT(a_held_nostr, state_reg.held_dash |-> (state_reg.delim == csf_pkg::DELIM_NONE), "dash held inside string")
    `CSF_ASSERT(a_block_lvl, (state_reg.mode == csf_pkg::MODE_BLOCK) |-> (state_reg.block_level != 5'd0 && state_reg.block_level <= 5'(csf_pkg::MAX_LEVEL)), "block level out of range")

endmodule

[tb/tb_comment_and_string_filter_unit.sv]
`timescale 1ns / 1ps
module tb_comment_and_string_filter_unit;
    import csf_pkg::*;

    localparam int TARGET_ITEMS = 650;
    localparam int ITEMS_PER_PHASE = 165;
    localparam int HEAVY_IDLE_PCT = 64;
    localparam int BOTH_IDLE_PCT = 34;
    localparam int DRAIN_CYCLES = 20;

    typedef enum int {
        PH_BUSY,
        PH_SEND_IDLE,
        PH_RECV_STALL,
        PH_BOTH_IDLE
    } idle_phase_t;

    // predicts the keep/skip fate of every character and checks the result stream
    class strip_scoreboard;
        result_t     expected_fates[$];
        int          mismatches;
        logic        held_dash;
        mode_t       mode;
        logic [4:0]  block_level;
        logic [4:0]  equals_run;
        logic        close_seen;
        delim_t      delim;
        logic        escape;

        function new();
            mismatches = 0;
            clear_state();
        endfunction

        function void clear_state();
            held_dash   = 1'b0;
            mode        = MODE_CODE;
            block_level = '0;
            equals_run  = '0;
            close_seen  = 1'b0;
            delim       = DELIM_NONE;
            escape      = 1'b0;
        endfunction

        function void add_fate(logic [OUT_BITS-1:0] ch, logic keep, logic last);
            result_t r;
            r.ch   = ch;
            r.keep = keep;
            r.last = last;
            expected_fates = {expected_fates, r};
        endfunction

        // character seen while inside a comment or a comment opening
        function void comment_step(logic [OUT_BITS-1:0] c);
            case (mode)
                MODE_DASHES: begin
                    if (c == CH_NL) begin
                        mode = MODE_CODE;
                    end else if (c == CH_OPEN) begin
                        mode = MODE_OPEN_EQ;
                        equals_run = '0;
                    end else begin
                        mode = MODE_LINE;
                    end
                end
                MODE_OPEN_EQ: begin
                    if (c == CH_OPEN) begin
                        mode = MODE_BLOCK;
                        block_level = equals_run + 5'd1;
                        equals_run = '0;
                        close_seen = 1'b0;
                    end else if (c == CH_EQ) begin
                        if (int'(equals_run) >= MAX_LEVEL - 1) begin
                            mode = MODE_LINE;
                            equals_run = '0;
                        end else begin
                            equals_run = equals_run + 5'd1;
                        end
                    end else if (c == CH_NL) begin
                        mode = MODE_CODE;
                        equals_run = '0;
                    end else begin
                        mode = MODE_LINE;
                        equals_run = '0;
                    end
                end
                MODE_LINE: begin
                    if (c == CH_NL) mode = MODE_CODE;
                end
                default: begin
                    // block comment: look for close bracket, level-1 equals, close bracket
                    if (c == CH_CLOSE) begin
                        if (close_seen && int'(equals_run) + 1 == int'(block_level)) begin
                            mode = MODE_CODE;
                            block_level = '0;
                            close_seen = 1'b0;
                        end else begin
                            close_seen = 1'b1;
                        end
                        equals_run = '0;
                    end else if (c == CH_EQ) begin
                        if (close_seen && equals_run < EQ_SAT) equals_run = equals_run + 5'd1;
                    end else begin
                        close_seen = 1'b0;
                        equals_run = '0;
                    end
                end
            endcase
        endfunction

        // kept character: track string literals and escapes
        function void code_step(logic [OUT_BITS-1:0] c);
            logic [OUT_BITS-1:0] closer;
            if (delim == DELIM_NONE) begin
                case (c)
                    CH_DQ:   delim = DELIM_DQ;
                    CH_SQ:   delim = DELIM_SQ;
                    CH_BQ:   delim = DELIM_BQ;
                    default: delim = DELIM_NONE;
                endcase
                escape = 1'b0;
            end else begin
                escape = (c == CH_BSL) && !escape;
                case (delim)
                    DELIM_DQ: closer = CH_DQ;
                    DELIM_SQ: closer = CH_SQ;
                    default:  closer = CH_BQ;
                endcase
                if (c == closer && !escape) delim = DELIM_NONE;
            end
        endfunction

        // accepted input transaction: queue the fates it decides
        function void predict_fate(logic [15:0] code, logic eot);
            logic [OUT_BITS-1:0] c;
            c = code;
            if (eot) begin
                if (held_dash) add_fate(CH_DASH, 1'b1, 1'b1);
                clear_state();
                return;
            end
            if (held_dash) begin
                held_dash = 1'b0;
                if (c == CH_DASH) begin
                    add_fate(CH_DASH, 1'b0, 1'b0);
                    add_fate(c, 1'b0, 1'b1);
                    mode = MODE_DASHES;
                    return;
                end
                add_fate(CH_DASH, 1'b1, 1'b0);
                code_step(c);
                add_fate(c, 1'b1, 1'b1);
                return;
            end
            if (mode != MODE_CODE) begin
                comment_step(c);
                add_fate(c, 1'b0, 1'b1);
                return;
            end
            if (delim == DELIM_NONE && c == CH_DASH) begin
                held_dash = 1'b1;
                return;
            end
            code_step(c);
            add_fate(c, 1'b1, 1'b1);
        endfunction

        // accepted result transaction: compare with the oldest expected fate
        function void check_fate(logic [15:0] ch, logic keep, logic last);
            result_t want;
            if (expected_fates.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual ch=%h keep=%b last=%b",
                         $time, ch, keep, last);
                mismatches++;
                return;
            end
            want = expected_fates.pop_front();
            if (want.ch !== ch || want.keep !== keep || want.last !== last) begin
                $display("%0t: mismatch: expected ch=%h keep=%b last=%b, actual ch=%h keep=%b last=%b",
                         $time, want.ch, want.keep, want.last, ch, keep, last);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return expected_fates.size();
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;     // [15:0] char_code
    logic        s_tlast = 1'b0;   // end_of_text
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;          // [15:0] out_char
    logic        m_tuser;          // [0] keep
    logic        m_tlast;          // last

    strip_scoreboard sb = new();
    idle_phase_t idle_phase = PH_BUSY;
    int sent_count = 0;

    comment_and_string_filter_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // result side: check each transaction, then choose next ready
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_fate(m_tdata, m_tuser, m_tlast);
        case (idle_phase)
            PH_RECV_STALL: m_tready <= ($urandom_range(99) >= HEAVY_IDLE_PCT);
            PH_BOTH_IDLE:  m_tready <= ($urandom_range(99) >= BOTH_IDLE_PCT);
            default:       m_tready <= 1'b1;
        endcase
    end

    // one input transaction, with random idle cycles ahead of it
    task automatic send_item(input logic [15:0] code, input logic eot);
        int pct;
        case (idle_phase)
            PH_SEND_IDLE: pct = HEAVY_IDLE_PCT;
            PH_BOTH_IDLE: pct = BOTH_IDLE_PCT;
            default:      pct = 0;
        endcase
        if (pct > 0 && $urandom_range(99) < pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        s_tlast  <= eot;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.predict_fate(code, eot);
        sent_count++;
        idle_phase = idle_phase_t'((sent_count / ITEMS_PER_PHASE) % 4);
    endtask

    task automatic send_run(input logic [15:0] code, input int count);
        repeat (count) send_item(code, 1'b0);
    endtask

    // "--[" followed by a run of equals
    task automatic send_open(input int eq_count);
        send_item(CH_DASH, 1'b0);
        send_item(CH_DASH, 1'b0);
        send_item(CH_OPEN, 1'b0);
        send_run(CH_EQ, eq_count);
    endtask

    function automatic logic [15:0] rand_special();
        case ($urandom_range(8))
            0:       return CH_DASH;
            1:       return CH_OPEN;
            2:       return CH_CLOSE;
            3:       return CH_EQ;
            4:       return CH_NL;
            5:       return CH_BSL;
            6:       return CH_DQ;
            7:       return CH_SQ;
            default: return CH_BQ;
        endcase
    endfunction

    function automatic logic [15:0] rand_quote();
        case ($urandom_range(2))
            0:       return CH_DQ;
            1:       return CH_SQ;
            default: return CH_BQ;
        endcase
    endfunction

    // printable text, some markup characters and full-width code units
    function automatic logic [15:0] rand_code_char();
        logic [15:0] sp;
        sp = rand_special();
        case ($urandom_range(9))
            0, 1, 2, 3: return 16'($urandom_range(16'h0020, 16'h007E));
            4, 5:       return sp;
            6, 7:       return 16'($urandom);
            // special low byte under a nonzero high byte must not match
            default:    return {8'($urandom_range(1, 255)), sp[7:0]};
        endcase
    endfunction

    // block comment at a random level with near-miss closes in its body
    task automatic send_block_comment();
        int level_eq;
        int body_len;
        level_eq = ($urandom_range(9) == 0) ? MAX_LEVEL - 1 : $urandom_range(3);
        body_len = $urandom_range(8);
        send_open(level_eq);
        send_item(CH_OPEN, 1'b0);
        for (int i = 0; i < body_len; i++) begin
            case ($urandom_range(19))
                0, 1, 2, 3, 4: send_item(CH_CLOSE, 1'b0);
                5, 6, 7, 8:    send_item(CH_EQ, 1'b0);
                9: begin
                    send_item(CH_CLOSE, 1'b0);
                    send_run(CH_EQ, level_eq + 1);
                    send_item(CH_CLOSE, 1'b0);
                end
                10: begin
                    if (level_eq > 0) begin
                        send_item(CH_CLOSE, 1'b0);
                        send_run(CH_EQ, level_eq - 1);
                        send_item(CH_CLOSE, 1'b0);
                    end
                end
                11: begin
                    // long equals run saturates the counter
                    if ($urandom_range(9) == 0) begin
                        send_item(CH_CLOSE, 1'b0);
                        send_run(CH_EQ, 33);
                        send_item(CH_CLOSE, 1'b0);
                    end
                end
                default: send_item(rand_code_char(), 1'b0);
            endcase
        end
        send_item(CH_CLOSE, 1'b0);
        send_run(CH_EQ, level_eq);
        send_item(CH_CLOSE, 1'b0);
    endtask

    // string literal with dashes, escapes and escaped quotes
    task automatic send_string();
        logic [15:0] q;
        int len;
        q = rand_quote();
        len = $urandom_range(6);
        send_item(q, 1'b0);
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(5))
                0: send_item(CH_DASH, 1'b0);
                1: begin
                    send_item(CH_BSL, 1'b0);
                    send_item(q, 1'b0);
                end
                2: begin
                    send_item(CH_BSL, 1'b0);
                    send_item(rand_code_char(), 1'b0);
                end
                default: send_item(rand_code_char(), 1'b0);
            endcase
        end
        send_item(q, 1'b0);
    endtask

    // one random fragment of source text
    task automatic send_snippet();
        int pick;
        int len;
        pick = $urandom_range(99);
        if (pick < 20) begin
            len = $urandom_range(1, 6);
            repeat (len) send_item(rand_code_char(), 1'b0);
        end else if (pick < 38) begin
            len = $urandom_range(6);
            send_item(CH_DASH, 1'b0);
            send_item(CH_DASH, 1'b0);
            repeat (len) send_item(rand_code_char(), 1'b0);
            send_item(CH_NL, 1'b0);
        end else if (pick < 58) begin
            send_block_comment();
        end else if (pick < 72) begin
            send_string();
        end else if (pick < 80) begin
            // opening that breaks off or ends at a newline
            case ($urandom_range(2))
                0: begin
                    send_item(CH_DASH, 1'b0);
                    send_item(CH_DASH, 1'b0);
                end
                1: send_open($urandom_range(3));
                default: begin
                    send_open($urandom_range(3));
                    send_item(rand_code_char(), 1'b0);
                end
            endcase
            send_item(CH_NL, 1'b0);
        end else if (pick < 85) begin
            // too many equals: falls back to a line comment
            send_open($urandom_range(MAX_LEVEL, MAX_LEVEL + 1));
            send_item(CH_OPEN, 1'b0);
            send_item(rand_code_char(), 1'b0);
            send_item(CH_NL, 1'b0);
        end else if (pick < 93) begin
            send_item(CH_DASH, 1'b0);
            if ($urandom_range(3) == 0) send_item(16'($urandom), 1'b1);
            else send_item(rand_code_char(), 1'b0);
        end else begin
            send_item(16'($urandom), 1'b1);
        end
    endtask

    // reset, directed cases, random text, drain and verdict
    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // code unit extremes
        send_item(16'h0000, 1'b0);
        send_item(16'hFFFF, 1'b0);
        // held dash released by another character
        send_item(CH_DASH, 1'b0);
        send_item("a", 1'b0);
        // dash pair, then newline right after it
        send_item(CH_DASH, 1'b0);
        send_item(CH_DASH, 1'b0);
        send_item(CH_NL, 1'b0);
        // newline inside an opening
        send_open(1);
        send_item(CH_NL, 1'b0);
        // opening broken into a line comment
        send_open(0);
        send_item("q", 1'b0);
        send_item(CH_NL, 1'b0);
        // end of text flushes a held dash, then end of text alone
        send_item(CH_DASH, 1'b0);
        send_item(16'hFFFF, 1'b1);
        send_item(16'h0000, 1'b1);
        // dashes and escaped quote inside a string
        send_item(CH_DQ, 1'b0);
        send_item(CH_DASH, 1'b0);
        send_item(CH_DASH, 1'b0);
        send_item(CH_BSL, 1'b0);
        send_item(CH_DQ, 1'b0);
        send_item(CH_DQ, 1'b0);

        while (sent_count < TARGET_ITEMS) send_snippet();
        s_tvalid <= 1'b0;

        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0) begin
            $display("comment_and_string_filter_unit regression: pass");
        end else begin
            $display("comment_and_string_filter_unit regression: fail");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("comment_and_string_filter_unit regression: fail");
        $finish;
    end

endmodule
